[sv/phpf_pkg.sv]
package phpf_pkg;

    // default sizes
    localparam int DEF_DIM_BITS    = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_COLUMN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ROW    = 1'b1;

    // character codes
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MODE_ASCII  = CH_ZERO + 8'd3;
    localparam logic [7:0] CH_MODE_BINARY = CH_ZERO + 8'd6;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_MODE,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_ASCII,
        PH_BINARY
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_MAGIC,
        ST_MODE,
        ST_BOUNDS,
        ST_EARLY
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_value;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } out_item_t;

    typedef struct packed {
        logic      emit;
        out_item_t item;
    } core_out_t;

endpackage

[sv/ppm_header_pixel_fetch.sv]
// PPM header parser and pixel fetch. Feed a PPM file one byte per transfer on the
// input channel, with last_byte set on its final byte. The block checks the 'P'
// magic, takes mode 3 (ASCII samples) or 6 (binary samples), skips whitespace and
// '#' comments, decodes width, height and maximum value, then walks the raster
// until it reaches pixel (target_row, target_column) and returns exactly one
// result per file: the RGB samples there, or an error status (bad magic,
// unsupported mode or maxval, target out of bounds, file ended early). Bytes
// after a result are swallowed until last_byte, after which the parser is ready
// for the next file. Rate: one byte per clock while the result register is free;
// each byte is parked in an input register and is parsed by a single pass of
// compare and decimal accumulate logic into the result register. The result
// register is the only thing that can hold bytes back: a byte moves on only
// while that register is empty or being drained. Target registers are written
// over the config channel (index 0 column, index 1 row); the user must do so
// only while no file is in flight, which the block itself does not enforce;
// cfg_ready is always high.
module ppm_header_pixel_fetch #(
    parameter int DIM_BITS    = phpf_pkg::DEF_DIM_BITS,
    parameter int SAMPLE_BITS = phpf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  phpf_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output phpf_pkg::out_item_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [phpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                          cfg_data
);
    import phpf_pkg::*;

    logic [15:0] target_col_reg;
    logic [15:0] target_row_reg;
    logic        out_free;
    logic        step;
    in_item_t    item;
    core_out_t   res;

    // configuration: always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_col_reg <= '0;
            target_row_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TARGET_COLUMN: target_col_reg <= cfg_data;
                CFG_TARGET_ROW:    target_row_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register: one byte parked ahead of the parser
    phpf_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_free (out_free),
        .step     (step),
        .item     (item)
    );

    // parser state and per-byte decode
    phpf_core #(
        .DIM_BITS    (DIM_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (item),
        .target_column (target_col_reg),
        .target_row    (target_row_reg),
        .res           (res)
    );

    // result register
    phpf_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> !step)
        else $error("configuration written while a byte is parsed");

endmodule

[sv/phpf_in_stage.sv]
module phpf_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  phpf_pkg::in_item_t in_data,
    input  logic               out_free,
    output logic               step,
    output phpf_pkg::in_item_t item
);
    import phpf_pkg::*;

    logic     hold_valid_reg;
    in_item_t hold_data_reg;

    // byte moves on when the result slot can take whatever it causes
    assign step     = hold_valid_reg && out_free;
    assign in_ready = !hold_valid_reg || step;
    assign item     = hold_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_data_reg <= in_data;
        end
    end

endmodule

[sv/phpf_core.sv]
module phpf_core #(
    parameter int DIM_BITS    = phpf_pkg::DEF_DIM_BITS,
    parameter int SAMPLE_BITS = phpf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  phpf_pkg::in_item_t  item,
    input  logic [15:0]         target_column,
    input  logic [15:0]         target_row,
    output phpf_pkg::core_out_t res
);
    import phpf_pkg::*;

    localparam int ACC_W = (DIM_BITS > 16) ? DIM_BITS : 16;
    localparam int MUL_W = ACC_W + 4;
    localparam logic [MUL_W-1:0] DIM_CAP    = MUL_W'((64'd1 << DIM_BITS) - 64'd1);
    localparam logic [MUL_W-1:0] SAMPLE_CAP = MUL_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [MUL_W-1:0] MAXVAL_CAP = MUL_W'(65535);

    phase_t                 phase_reg, phase_next;
    logic                   binary_reg, binary_next;
    logic                   comment_reg, comment_next;
    logic                   have_reg, have_next;
    logic                   finished_reg, finished_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [DIM_BITS-1:0]    width_reg, width_next;
    logic [DIM_BITS-1:0]    height_reg, height_next;
    logic [15:0]            maxval_reg, maxval_next;
    logic [DIM_BITS-1:0]    col_reg, col_next;
    logic [DIM_BITS-1:0]    row_reg, row_next;
    logic [1:0]             chan_reg, chan_next;
    logic [SAMPLE_BITS-1:0] red_reg, red_next;
    logic [SAMPLE_BITS-1:0] green_reg, green_next;

    logic                   emit;
    status_t                emit_status;
    logic [SAMPLE_BITS-1:0] blue_val;
    logic                   fin_req;
    logic [ACC_W-1:0]       fin_val;
    logic                   samp_req;
    logic [SAMPLE_BITS-1:0] samp_val;
    logic                   hash_pending;
    logic                   is_digit;
    logic                   is_white;
    logic [MUL_W-1:0]       prod;
    logic [MUL_W-1:0]       cap;
    logic [15:0]            pair;
    logic [DIM_BITS-1:0]    col_inc;
    logic [ACC_W-1:0]       width_ext;
    logic [ACC_W-1:0]       height_ext;

    assign is_digit = (item.data_byte >= CH_ZERO) && (item.data_byte <= CH_NINE);
    assign is_white = item.data_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    assign pair     = {acc_reg[7:0], item.data_byte};
    assign col_inc  = col_reg + DIM_BITS'(1);

    // decimal digit: acc*10 + d, saturated at the cap of the current field
    always_comb
    begin
        prod = (MUL_W'(acc_reg) << 3) + (MUL_W'(acc_reg) << 1)
             + MUL_W'(item.data_byte - CH_ZERO);
        case (phase_reg)
            PH_WIDTH, PH_HEIGHT: cap = DIM_CAP;
            PH_MAXVAL:           cap = MAXVAL_CAP;
            default:             cap = SAMPLE_CAP;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        binary_next   = binary_reg;
        comment_next  = comment_reg;
        have_next     = have_reg;
        acc_next      = acc_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        maxval_next   = maxval_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        chan_next     = chan_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        emit          = 1'b0;
        emit_status   = ST_OK;
        blue_val      = '0;
        fin_req       = 1'b0;
        fin_val       = acc_reg;
        samp_req      = 1'b0;
        samp_val      = '0;
        hash_pending  = 1'b0;

        if (step)
        begin
            // byte handling
            if (!finished_reg)
            begin
                if (phase_reg == PH_BINARY)
                begin
                    if (maxval_reg[15:8] == '0)
                    begin
                        samp_req = 1'b1;
                        samp_val = SAMPLE_BITS'(item.data_byte);
                    end
                    else if (!have_reg)
                    begin
                        acc_next  = ACC_W'(item.data_byte);
                        have_next = 1'b1;
                    end
                    else
                    begin
                        acc_next  = '0;
                        have_next = 1'b0;
                        samp_req  = 1'b1;
                        samp_val  = (MUL_W'(pair) > SAMPLE_CAP) ? '1 : SAMPLE_BITS'(pair);
                    end
                end
                else if (comment_reg)
                begin
                    if (item.data_byte == CH_LF || item.data_byte == CH_CR)
                    begin
                        comment_next = 1'b0;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_MAGIC:
                        begin
                            if (is_white)
                            begin
                            end
                            else if (item.data_byte == CH_HASH)
                            begin
                                comment_next = 1'b1;
                            end
                            else if (item.data_byte == CH_P)
                            begin
                                phase_next = PH_MODE;
                            end
                            else
                            begin
                                emit        = 1'b1;
                                emit_status = ST_MAGIC;
                            end
                        end
                        PH_MODE:
                        begin
                            if (item.data_byte == CH_MODE_ASCII)
                            begin
                                binary_next = 1'b0;
                                phase_next  = PH_WIDTH;
                            end
                            else if (item.data_byte == CH_MODE_BINARY)
                            begin
                                binary_next = 1'b1;
                                phase_next  = PH_WIDTH;
                            end
                            else
                            begin
                                emit        = 1'b1;
                                emit_status = ST_MODE;
                            end
                        end
                        PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII:
                        begin
                            if (is_digit)
                            begin
                                acc_next  = (prod > cap) ? ACC_W'(cap) : ACC_W'(prod);
                                have_next = 1'b1;
                            end
                            else
                            begin
                                fin_req      = have_reg;
                                fin_val      = acc_reg;
                                hash_pending = (item.data_byte == CH_HASH);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // end of file completes a pending number
            if (item.last_byte && !finished_reg && !fin_req && !emit && have_next
                && (phase_next inside {PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII}))
            begin
                fin_req = 1'b1;
                fin_val = acc_next;
            end

            // number complete
            if (fin_req)
            begin
                acc_next  = '0;
                have_next = 1'b0;
                case (phase_next)
                    PH_WIDTH:
                    begin
                        width_next = DIM_BITS'(fin_val);
                        if (ACC_W'(target_column) >= fin_val)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_BOUNDS;
                        end
                        else
                        begin
                            phase_next = PH_HEIGHT;
                        end
                    end
                    PH_HEIGHT:
                    begin
                        height_next = DIM_BITS'(fin_val);
                        if (ACC_W'(target_row) >= fin_val)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_BOUNDS;
                        end
                        else
                        begin
                            phase_next = PH_MAXVAL;
                        end
                    end
                    PH_MAXVAL:
                    begin
                        maxval_next = fin_val[15:0];
                        if (fin_val == '0 || MUL_W'(fin_val) > SAMPLE_CAP)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_MODE;
                        end
                        else
                        begin
                            phase_next = binary_reg ? PH_BINARY : PH_ASCII;
                        end
                    end
                    PH_ASCII:
                    begin
                        samp_req = 1'b1;
                        samp_val = SAMPLE_BITS'(fin_val);
                    end
                    default:
                    begin
                    end
                endcase
            end

            // sample into the pixel being assembled
            if (samp_req)
            begin
                case (chan_reg)
                    2'd0:
                    begin
                        red_next  = samp_val;
                        chan_next = 2'd1;
                    end
                    2'd1:
                    begin
                        green_next = samp_val;
                        chan_next  = 2'd2;
                    end
                    default:
                    begin
                        chan_next = 2'd0;
                        if (ACC_W'(col_reg) == ACC_W'(target_column)
                            && ACC_W'(row_reg) == ACC_W'(target_row))
                        begin
                            emit        = 1'b1;
                            emit_status = ST_OK;
                            blue_val    = samp_val;
                        end
                        else if (col_inc >= width_reg)
                        begin
                            col_next = '0;
                            row_next = row_reg + DIM_BITS'(1);
                        end
                        else
                        begin
                            col_next = col_inc;
                        end
                    end
                endcase
            end

            if (hash_pending && !emit && phase_next != PH_BINARY)
            begin
                comment_next = 1'b1;
            end

            if (item.last_byte && !finished_reg && !emit)
            begin
                emit        = 1'b1;
                emit_status = ST_EARLY;
            end
        end

        finished_next = finished_reg || emit;
    end

    // result
    always_comb
    begin
        width_ext              = ACC_W'(width_next);
        height_ext             = ACC_W'(height_next);
        res.emit               = emit;
        res.item.status        = emit_status;
        res.item.image_width   = width_ext[15:0];
        res.item.image_height  = height_ext[15:0];
        res.item.max_value     = maxval_next;
        res.item.red           = '0;
        res.item.green         = '0;
        res.item.blue          = '0;
        if (emit_status == ST_OK)
        begin
            res.item.red   = 16'(red_reg);
            res.item.green = 16'(green_reg);
            res.item.blue  = 16'(blue_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            binary_reg   <= 1'b0;
            comment_reg  <= 1'b0;
            have_reg     <= 1'b0;
            finished_reg <= 1'b0;
            acc_reg      <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            maxval_reg   <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            chan_reg     <= '0;
            red_reg      <= '0;
            green_reg    <= '0;
        end
        else if (step && item.last_byte)
        begin
            // file done: back to the start for the next one
            phase_reg    <= PH_MAGIC;
            binary_reg   <= 1'b0;
            comment_reg  <= 1'b0;
            have_reg     <= 1'b0;
            finished_reg <= 1'b0;
            acc_reg      <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            maxval_reg   <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            chan_reg     <= '0;
            red_reg      <= '0;
            green_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            binary_reg   <= binary_next;
            comment_reg  <= comment_next;
            have_reg     <= have_next;
            finished_reg <= finished_next;
            acc_reg      <= acc_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            maxval_reg   <= maxval_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            chan_reg     <= chan_next;
            red_reg      <= red_next;
            green_reg    <= green_next;
        end
    end

    a_quiet_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !res.emit)
        else $error("second result within one file");

    a_clear_at_file_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=> phase_reg == PH_MAGIC && !finished_reg && !have_reg)
        else $error("parser not cleared after final byte");

    a_pixel_in_raster: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit && res.item.status == ST_OK |-> phase_reg == PH_ASCII
                                                 || phase_reg == PH_BINARY)
        else $error("pixel result outside the raster");

    a_early_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit && res.item.status == ST_EARLY |-> step && item.last_byte)
        else $error("early-end status without final byte");

endmodule

[sv/phpf_out_stage.sv]
module phpf_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  phpf_pkg::core_out_t res,
    output logic                out_free,
    output logic                out_valid,
    input  logic                out_ready,
    output phpf_pkg::out_item_t out_data
);
    import phpf_pkg::*;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.emit)
        begin
            out_data_reg <= res.item;
        end
    end

endmodule
